// ----- src/fgre_pkg.sv -----
`default_nettype none
package fgre_pkg;

    localparam int GLYPH_ROWS       = 8;
    localparam int GLYPHS_PER_BLOCK = 32;
    localparam int ROM_BLOCKS       = 3;
    localparam int ROM_DEPTH        = ROM_BLOCKS * GLYPH_ROWS * GLYPHS_PER_BLOCK;
    localparam int ROM_AW           = $clog2(ROM_DEPTH);
    localparam int ROW_W            = $clog2(GLYPH_ROWS);
    localparam int COL_W            = $clog2(GLYPHS_PER_BLOCK);
    localparam int LINE_W           = ROM_AW - COL_W;

    // printable range held in the font
    localparam logic [7:0] CODE_FIRST = 8'd33;
    localparam logic [7:0] CODE_LAST  = 8'd126;

    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(GLYPH_ROWS - 1);

    // configuration register indexes
    localparam logic [1:0] CFG_PIXEL_MODE = 2'd0;
    localparam logic [1:0] CFG_FG_PEN     = 2'd1;
    localparam logic [1:0] CFG_BG_PEN     = 2'd2;

    // pixel modes
    localparam logic [1:0] MODE_PEN4 = 2'd0;
    localparam logic [1:0] MODE_PEN2 = 2'd1;

    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = $clog2(RQ_DEPTH);
    localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

    typedef struct packed {
        logic [1:0] pixel_mode;
        logic [3:0] fg_pen;
        logic [3:0] bg_pen;
    } t_cfg;

    // classified character, as queued between front and back
    typedef struct packed {
        logic              in_range;
        logic [LINE_W-1:0] top_line;
        logic [COL_W-1:0]  col;
    } t_item;

    typedef struct packed {
        logic [31:0]      row_pixels;
        logic [ROW_W-1:0] row_index;
        logic             last_row;
    } t_res;

    // font storage: line (3-b)*8-1-r holds row r of block b, 32 glyphs a line
    localparam logic [7:0] GLYPH_ROM [ROM_DEPTH] = '{
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h3E,8'h00,
        8'h00,8'h1E,8'h00,8'h00,8'h00,8'h00,8'h00,8'h78,
        8'h0F,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h3E,8'h00,8'h00,8'h00,8'h00,8'h00,8'h19,8'h80,
        8'h3B,8'h6E,8'h1E,8'h3B,8'h1E,8'h3C,8'h03,8'h73,
        8'h1E,8'h33,8'h73,8'h1E,8'h63,8'h33,8'h1E,8'h30,
        8'h06,8'h78,8'h3E,8'h0E,8'h1F,8'h0C,8'h36,8'h63,
        8'h03,8'h3F,8'h07,8'h0C,8'h38,8'h00,8'h66,8'h00,
        8'h66,8'h33,8'h33,8'h66,8'h30,8'h18,8'h1F,8'h33,
        8'h0C,8'h33,8'h36,8'h0C,8'h6B,8'h33,8'h33,8'h3E,
        8'h3E,8'h30,8'h03,8'h1B,8'h33,8'h1E,8'h7F,8'h36,
        8'h1F,8'h19,8'h0C,8'h0C,8'h0C,8'h00,8'h19,8'h80,
        8'h3E,8'h33,8'h30,8'h66,8'h3F,8'h18,8'h33,8'h33,
        8'h0C,8'h03,8'h3C,8'h0C,8'h6B,8'h33,8'h33,8'h33,
        8'h66,8'h30,8'h1E,8'h18,8'h33,8'h33,8'h6B,8'h1C,
        8'h33,8'h0C,8'h0C,8'h0C,8'h0C,8'h00,8'h66,8'h00,
        8'h06,8'h33,8'h33,8'h66,8'h33,8'h3C,8'h33,8'h3B,
        8'h0C,8'h03,8'h36,8'h0C,8'h7F,8'h33,8'h33,8'h33,
        8'h66,8'h3B,8'h30,8'h18,8'h33,8'h33,8'h6B,8'h36,
        8'h33,8'h26,8'h38,8'h0C,8'h07,8'h00,8'h19,8'h80,
        8'h3C,8'h3E,8'h1E,8'h3E,8'h1E,8'h18,8'h1F,8'h36,
        8'h1C,8'h07,8'h33,8'h0C,8'h36,8'h6E,8'h1E,8'h6E,
        8'h3B,8'h6E,8'h1E,8'h3E,8'h33,8'h33,8'h63,8'h63,
        8'h33,8'h3F,8'h0C,8'h0C,8'h0C,8'h00,8'h66,8'h00,
        8'h00,8'h30,8'h00,8'h06,8'h00,8'h1B,8'h00,8'h30,
        8'h00,8'h00,8'h30,8'h0C,8'h00,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h00,8'h18,8'h00,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h0C,8'h0C,8'h0C,8'h6E,8'h19,8'h80,
        8'h00,8'h70,8'h00,8'h0E,8'h00,8'h0E,8'h00,8'h70,
        8'h0C,8'h03,8'h70,8'h1C,8'h00,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h00,8'h18,8'h00,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h07,8'h0C,8'h38,8'h3B,8'h66,8'h00,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h7F,8'h80,
        8'h33,8'h7E,8'h1E,8'h7C,8'h7F,8'h78,8'h1F,8'h33,
        8'h3F,8'h3C,8'h73,8'h7F,8'h63,8'h63,8'h1C,8'h78,
        8'h3B,8'h73,8'h1E,8'h1E,8'h1E,8'h0C,8'h63,8'h63,
        8'h1E,8'h7F,8'h1E,8'h01,8'h1E,8'h0C,8'h00,8'h00,
        8'h33,8'h33,8'h33,8'h36,8'h31,8'h30,8'h33,8'h33,
        8'h0C,8'h66,8'h33,8'h33,8'h63,8'h63,8'h36,8'h30,
        8'h66,8'h33,8'h33,8'h0C,8'h33,8'h1E,8'h77,8'h63,
        8'h0C,8'h33,8'h18,8'h03,8'h06,8'h0C,8'h00,8'h00,
        8'h3F,8'h33,8'h60,8'h33,8'h34,8'h34,8'h67,8'h33,
        8'h0C,8'h66,8'h36,8'h31,8'h6B,8'h67,8'h63,8'h30,
        8'h6D,8'h36,8'h03,8'h0C,8'h33,8'h33,8'h7F,8'h36,
        8'h0C,8'h19,8'h18,8'h06,8'h06,8'h0C,8'h00,8'h00,
        8'h33,8'h3E,8'h60,8'h33,8'h3C,8'h3C,8'h60,8'h3F,
        8'h0C,8'h06,8'h3C,8'h30,8'h7F,8'h6F,8'h63,8'h3E,
        8'h63,8'h3E,8'h1E,8'h0C,8'h33,8'h33,8'h6B,8'h1C,
        8'h1E,8'h0C,8'h18,8'h0C,8'h06,8'h0C,8'h00,8'h00,
        8'h33,8'h33,8'h60,8'h33,8'h34,8'h34,8'h60,8'h33,
        8'h0C,8'h06,8'h36,8'h30,8'h7F,8'h7B,8'h63,8'h33,
        8'h63,8'h33,8'h30,8'h0C,8'h33,8'h33,8'h63,8'h1C,
        8'h33,8'h46,8'h18,8'h18,8'h06,8'h3F,8'h00,8'h06,
        8'h1E,8'h33,8'h33,8'h36,8'h31,8'h31,8'h33,8'h33,
        8'h0C,8'h06,8'h33,8'h30,8'h77,8'h73,8'h36,8'h33,
        8'h36,8'h33,8'h33,8'h2D,8'h33,8'h33,8'h63,8'h36,
        8'h33,8'h63,8'h18,8'h30,8'h06,8'h1E,8'h00,8'h0C,
        8'h0C,8'h7E,8'h1E,8'h7C,8'h7F,8'h7F,8'h1E,8'h33,
        8'h3F,8'h0F,8'h73,8'h78,8'h63,8'h63,8'h1C,8'h7E,
        8'h1C,8'h7E,8'h1E,8'h3F,8'h33,8'h33,8'h63,8'h63,
        8'h33,8'h7F,8'h1E,8'h60,8'h1E,8'h0C,8'h00,8'h18,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h00,8'h18,8'h00,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h18,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h0C,8'h00,8'h36,8'h0C,8'h63,8'h3B,8'h00,8'h06,
        8'h18,8'h00,8'h00,8'h0C,8'h00,8'h0C,8'h40,8'h3E,
        8'h3F,8'h3F,8'h1E,8'h0F,8'h1E,8'h1E,8'h0C,8'h1E,
        8'h1E,8'h0C,8'h0C,8'h06,8'h00,8'h30,8'h0C,8'h3E,
        8'h00,8'h00,8'h36,8'h3E,8'h33,8'h66,8'h00,8'h0C,
        8'h0C,8'h33,8'h0C,8'h0C,8'h00,8'h0C,8'h60,8'h63,
        8'h0C,8'h33,8'h33,8'h06,8'h33,8'h33,8'h0C,8'h33,
        8'h33,8'h0C,8'h0C,8'h0C,8'h3F,8'h18,8'h00,8'h60,
        8'h0C,8'h00,8'h7F,8'h0D,8'h18,8'h6E,8'h00,8'h18,
        8'h06,8'h1E,8'h0C,8'h00,8'h00,8'h00,8'h30,8'h73,
        8'h0C,8'h30,8'h03,8'h7F,8'h03,8'h33,8'h0C,8'h33,
        8'h03,8'h00,8'h00,8'h18,8'h00,8'h0C,8'h0C,8'h6F,
        8'h0C,8'h00,8'h36,8'h1E,8'h0C,8'h3B,8'h00,8'h18,
        8'h06,8'h7F,8'hBF,8'h00,8'h3F,8'h00,8'h18,8'h6B,
        8'h0C,8'h1E,8'h0E,8'h66,8'h3E,8'h3E,8'h06,8'h1E,
        8'h1F,8'h0C,8'h0C,8'h30,8'h00,8'h06,8'h06,8'h6F,
        8'h0C,8'h36,8'h7F,8'h2C,8'h66,8'h1C,8'h18,8'h18,
        8'h06,8'h1E,8'h0C,8'h00,8'h00,8'h00,8'h0C,8'h67,
        8'h0C,8'h03,8'h03,8'h36,8'h30,8'h30,8'h03,8'h33,
        8'h33,8'h0C,8'h0C,8'h18,8'h3F,8'h0C,8'h33,8'h6F,
        8'h0C,8'h36,8'h36,8'h1F,8'h63,8'h36,8'h0C,8'h0C,
        8'h0C,8'h33,8'h0C,8'h00,8'h00,8'h00,8'h06,8'h63,
        8'h1C,8'h33,8'h33,8'h1E,8'h31,8'h33,8'h33,8'h33,
        8'h33,8'h00,8'h00,8'h0C,8'h00,8'h18,8'h33,8'h63,
        8'h0C,8'h36,8'h36,8'h0C,8'h00,8'h1C,8'h0C,8'h06,
        8'h18,8'h00,8'h00,8'h00,8'h00,8'h00,8'h03,8'h3E,
        8'h0C,8'h1E,8'h1E,8'h0E,8'h3F,8'h1E,8'h3F,8'h1E,
        8'h1E,8'h00,8'h00,8'h06,8'h00,8'h30,8'h1E,8'h3E
    };

    // glyph byte to packed pixel bytes, bit 7 of the glyph is leftmost
    function automatic logic [31:0] expand_row(input logic [7:0] g, input t_cfg cfg);
        logic [31:0] w;
        w = '0;
        case (cfg.pixel_mode)
            MODE_PEN4: begin
                for (int k = 0; k < 4; k++) begin
                    w[8*k+4 +: 4] = g[7-2*k] ? cfg.fg_pen : cfg.bg_pen;
                    w[8*k   +: 4] = g[6-2*k] ? cfg.fg_pen : cfg.bg_pen;
                end
            end
            MODE_PEN2: begin
                for (int k = 0; k < 2; k++) begin
                    for (int j = 0; j < 4; j++) begin
                        w[8*k+2*j +: 2] = g[4-4*k+j] ? cfg.fg_pen[1:0] : cfg.bg_pen[1:0];
                    end
                end
            end
            default: begin
                // one bit per pixel, mode three behaves the same
                w[7:0] = cfg.fg_pen[0] ? g : 8'h00;
            end
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// ----- src/fgre_front.sv -----
`default_nettype none
module fgre_front
    import fgre_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    input  wire logic [7:0] i_char_code,
    output logic            full,
    input  wire logic       i_q_pop,
    output logic            o_q_empty,
    output t_item           o_q_item
);

    localparam int FQ_DEPTH = 2;

    t_item      r_mem [FQ_DEPTH];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count,  n_count;

    t_item      cls;
    logic [7:0] gidx;
    logic       wr_en;
    logic       rd_en;

    // classify: glyph number, its column and the storage line of its top row
    always_comb begin
        gidx            = i_char_code - CODE_FIRST;
        cls.in_range    = (i_char_code >= CODE_FIRST) && (i_char_code <= CODE_LAST);
        cls.col         = gidx[COL_W-1:0];
        cls.top_line    = LINE_W'(ROM_BLOCKS * GLYPH_ROWS - 1)
                        - {gidx[COL_W+1:COL_W], 3'b000};
    end

    assign full      = (r_count == 2'(FQ_DEPTH));
    assign o_q_empty = (r_count == 2'd0);
    assign o_q_item  = r_mem[r_rd_ptr];
    assign wr_en     = push && !full;
    assign rd_en     = i_q_pop && !o_q_empty;

    always_comb begin
        n_wr_ptr = wr_en ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = rd_en ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, wr_en} - {1'b0, rd_en};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= cls;
        end
    end

    a_fq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'(FQ_DEPTH))
        else $error("front queue count out of range");

endmodule
`default_nettype wire

// ----- src/fgre_rbuf.sv -----
`default_nettype none
module fgre_rbuf
    import fgre_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_wr,
    input  wire t_res        i_wr_res,
    output logic [RQ_CW-1:0] o_count,
    output logic             empty,
    input  wire logic        pop,
    output t_res             o_res
);

    t_res             r_mem [RQ_DEPTH];
    logic [RQ_AW-1:0] r_wr_ptr;
    logic [RQ_AW-1:0] r_rd_ptr;
    logic [RQ_CW-1:0] r_count, n_count;
    logic             rd_en;

    assign empty   = (r_count == '0);
    assign o_res   = r_mem[r_rd_ptr];
    assign o_count = r_count;
    assign rd_en   = pop && !empty;
    assign n_count = r_count + RQ_CW'(i_wr) - RQ_CW'(rd_en);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + RQ_AW'(1);
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + RQ_AW'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_res;
        end
    end

    // the back end reserves room before it reads the font, so no overflow
    a_rq_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |-> (r_count < RQ_CW'(RQ_DEPTH) || rd_en))
        else $error("result queue written while full");

endmodule
`default_nettype wire

// ----- src/fgre_back.sv -----
`default_nettype none
module fgre_back
    import fgre_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cfg        i_cfg,
    input  wire logic        i_q_empty,
    input  wire t_item       i_q_item,
    output logic             o_q_pop,
    input  wire logic [RQ_CW-1:0] i_rq_count,
    output logic             o_rq_wr,
    output t_res             o_rq_res
);

    t_item            r_cur;
    logic             r_busy;
    logic [ROW_W-1:0] r_row;

    logic             r_rd_vld;
    logic [7:0]       r_rom_q;
    logic [ROW_W-1:0] r_rd_row;
    logic             r_rd_last;
    logic             r_rd_ok;

    logic              space;
    logic              issue;
    logic              load;
    logic              at_last;
    logic [LINE_W-1:0] line;
    logic [ROM_AW-1:0] rom_addr;
    logic [7:0]        glyph;

    // one row may be in flight in the font read, count it against the room left
    assign space    = ({1'b0, i_rq_count} + (RQ_CW+1)'(r_rd_vld)) < (RQ_CW+1)'(RQ_DEPTH);
    assign issue    = r_busy && space;
    assign at_last  = (r_row == ROW_LAST);
    assign load     = !i_q_empty && (!r_busy || (issue && at_last));
    assign o_q_pop  = load;
    assign line     = r_cur.top_line - LINE_W'(r_row);
    assign rom_addr = {line, r_cur.col};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_row    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= issue;
            if (load) begin
                r_busy <= 1'b1;
                r_row  <= '0;
            end else if (issue) begin
                r_row <= r_row + ROW_W'(1);
                if (at_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cur <= i_q_item;
        end
    end

    // font read, registered
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rom_q   <= GLYPH_ROM[rom_addr];
            r_rd_row  <= r_row;
            r_rd_last <= at_last;
            r_rd_ok   <= r_cur.in_range;
        end
    end

    assign glyph               = r_rd_ok ? r_rom_q : 8'h00;
    assign o_rq_wr             = r_rd_vld;
    assign o_rq_res.row_pixels = expand_row(glyph, i_cfg);
    assign o_rq_res.row_index  = r_rd_row;
    assign o_rq_res.last_row   = r_rd_last;

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_rd_last == (r_rd_row == ROW_LAST)))
        else $error("last flag out of step with row number");

    a_row_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue && !load) |=> (r_row == $past(r_row) + ROW_W'(1)))
        else $error("row counter did not advance");

    a_stay_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !at_last) |=> r_busy)
        else $error("character dropped before its last row");

endmodule
`default_nettype wire

// ----- src/font_glyph_row_expander_core.sv -----
// 8x8 character generator: one character code in, eight pixel rows out
//
// input channel: the code is offered on i_char_code with push; it is taken
// at a clock edge with push high and full low. the front end classifies it
// (printable or not, font column and storage line) into a two-word queue
// result channel: while empty is low the oldest row is on o_row_pixels,
// o_row_index and o_last_row; pop at a clock edge with empty low takes it.
// rows leave top first, row seven carries o_last_row
// path: the first row of a code passes the front queue, the character register,
// the registered font read and the result queue before it reaches the result ports
// throughput: one row a cycle while the result queue has room, set by the single read
// port of the font rom; codes follow one another with no gap
// stall: a four-word result queue parts the back end from the receiver; the
// back end reads a row only when a queue place is free, so a held pop just
// pauses the row sequence and the front queue then fills and raises full
// configuration: i_cfg_we writes i_cfg_wdata into register i_cfg_idx (0 pixel
// mode, 1 fg pen, 2 bg pen, index 3 ignored); write only while idle
// reset (synchronous, active low): queues emptied, pixel mode 0, fg pen 1,
// bg pen 0. the font rom is fixed and needs no clearing
`default_nettype none
module font_glyph_row_expander_core
    import fgre_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // character words
    input  wire logic        push,
    input  wire logic [7:0]  i_char_code,
    output logic             full,
    // row words
    output logic             empty,
    input  wire logic        pop,
    output logic [31:0]      o_row_pixels,
    output logic [2:0]       o_row_index,
    output logic             o_last_row,
    // configuration writes
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [3:0]  i_cfg_wdata
);

    t_cfg             r_cfg;
    logic             q_empty;
    t_item            q_item;
    logic             q_pop;
    logic [RQ_CW-1:0] rq_count;
    logic             rq_wr;
    t_res             rq_wr_res;
    t_res             rq_res;

    // configuration registers, masked to their widths
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pixel_mode <= MODE_PEN4;
            r_cfg.fg_pen     <= 4'd1;
            r_cfg.bg_pen     <= 4'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PIXEL_MODE: r_cfg.pixel_mode <= i_cfg_wdata[1:0];
                CFG_FG_PEN:     r_cfg.fg_pen     <= i_cfg_wdata;
                CFG_BG_PEN:     r_cfg.bg_pen     <= i_cfg_wdata;
                default: begin
                    // no register at this index
                end
            endcase
        end
    end

    // front end: classify and queue
    fgre_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_char_code (i_char_code),
        .full        (full),
        .i_q_pop     (q_pop),
        .o_q_empty   (q_empty),
        .o_q_item    (q_item)
    );

    // back end: row sequencer, font read and pen expansion
    fgre_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_empty  (q_empty),
        .i_q_item   (q_item),
        .o_q_pop    (q_pop),
        .i_rq_count (rq_count),
        .o_rq_wr    (rq_wr),
        .o_rq_res   (rq_wr_res)
    );

    // result queue towards the receiver
    fgre_rbuf u_rbuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (rq_wr),
        .i_wr_res (rq_wr_res),
        .o_count  (rq_count),
        .empty    (empty),
        .pop      (pop),
        .o_res    (rq_res)
    );

    assign o_row_pixels = rq_res.row_pixels;
    assign o_row_index  = rq_res.row_index;
    assign o_last_row   = rq_res.last_row;

endmodule
`default_nettype wire
